/* design/tfc_pkg.sv */
// Shared widths, types and rounding helpers for the triangle tangent frame core.
package tfc_pkg;

   // Lane width of every packed vector component (three lanes fill a 48-bit word).
   localparam int LANE_W    = 16;
   localparam int VEC_W     = 3 * LANE_W;
   localparam int UV_W      = 2 * LANE_W;
   localparam int FRAC      = 14;
   localparam int DIFF_W    = LANE_W + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int DET_W     = PROD_W + 1;
   localparam int U_W       = PROD_W + 2;
   localparam int NP_W      = U_W + LANE_W;
   localparam int DOT_W     = NP_W + 2;
   localparam int D_W       = DOT_W - FRAC + 1;
   localparam int DN_W      = D_W + LANE_W;
   localparam int P_W       = DN_W - FRAC + 1;
   localparam int A_W       = 30;
   localparam int SH_W      = $clog2(P_W - A_W + 1);
   localparam int SQ_W      = 2 * A_W + 2;
   localparam int ISQ_STEPS = SQ_W / 2;
   localparam int ROOT_W    = A_W + 1;
   localparam int Q_W       = FRAC + 1;
   localparam int NUM_W     = A_W + FRAC + 1;

   typedef logic [2:0][VEC_W-1:0] vec3_type;
   typedef logic [2:0][UV_W-1:0]  uv3_type;
   typedef logic [2:0][U_W-1:0]   uvec_type;

   typedef struct packed {
      logic [2:0][A_W-1:0] mag;
      logic [2:0]          neg;
      logic                zero;
   } nrm_side_type;

   typedef struct packed {
      logic [2:0][Q_W-1:0] quot;
      logic [2:0]          neg;
      logic                zero;
   } tng_res_type;

   // Sign-extended difference of two lanes.
   function automatic logic [DIFF_W-1:0] sdiff(input logic [LANE_W-1:0] a,
                                                input logic [LANE_W-1:0] b);
      return {a[LANE_W-1], a} - {b[LANE_W-1], b};
   endfunction

   // round(x / 2^FRAC), ties away from zero.
   function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] x);
      logic [63:0] m;
      logic [63:0] r;
      m = x[63] ? 64'(-x) : 64'(x);
      r = (m + (64'd1 << (FRAC - 1))) >> FRAC;
      return x[63] ? -$signed(r) : $signed(r);
   endfunction

endpackage

/* design/triangle_tangent_frame_core.sv */
// Top level of the per-triangle tangent frame pipeline.
//
//  channel | ports         | contents (lowest bit first)
//  --------+---------------+--------------------------------------------------
//  request | req_t*        | tdata: pos_a pos_b pos_c uv_a uv_b uv_c
//          |               |        normal_a normal_b normal_c
//  result  | rsp_t*        | tdata: tangent_a tangent_b tangent_c
//          |               | tuser: degenerate
//
//  One triangle per cycle enters while no result is held; each passes through the setup,
//  projection, square-root and divide pipes in that order, then the output register.
//  Synchronous reset clears every valid bit; payload registers are not reset.
//  A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module triangle_tangent_frame_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_a, pos_b, pos_c, uv_a, uv_b, uv_c, normal_a, normal_b, normal_c
   input  logic [383:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tangent_a, tangent_b, tangent_c
   output logic [143:0] rsp_tdata,
   // degenerate
   output logic [0:0]   rsp_tuser
);
   import tfc_pkg::*;

   logic                 adv;
   vec3_type             pos, nrm, nrm_s;
   uv3_type              uv;
   logic                 su_valid, det_zero;
   uvec_type             u_vec;
   logic [2:0]           pj_valid, sq_valid, dv_valid;
   logic [SQ_W-1:0]      sum_sq [3];
   nrm_side_type         pj_side [3];
   nrm_side_type         sq_side [3];
   logic [ROOT_W-1:0]    root [3];
   tng_res_type          res [3];
   logic [143:0]         data_in, rsp_tdata_ff;
   logic                 deg_in, rsp_tuser_ff, rsp_tvalid_ff;
   logic [LANE_W-1:0]    lane_val;

   // Advance every stage together unless a result is held.
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pos[k] = req_tdata[k*VEC_W +: VEC_W];
         uv[k]  = req_tdata[3*VEC_W + k*UV_W +: UV_W];
         nrm[k] = req_tdata[3*VEC_W + 3*UV_W + k*VEC_W +: VEC_W];
      end
   end

   tfc_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .pos       (pos),
      .uv        (uv),
      .nrm       (nrm),
      .out_valid (su_valid),
      .u_vec     (u_vec),
      .det_zero  (det_zero),
      .nrm_out   (nrm_s)
   );

   for (genvar v = 0; v < 3; v++) begin : g_vertex
      tfc_project u_project (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (su_valid),
         .u_vec     (u_vec),
         .nrm       (nrm_s[v]),
         .det_zero  (det_zero),
         .out_valid (pj_valid[v]),
         .sum_sq    (sum_sq[v]),
         .side      (pj_side[v])
      );

      tfc_isqrt u_isqrt (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (pj_valid[v]),
         .radicand  (sum_sq[v]),
         .side_in   (pj_side[v]),
         .out_valid (sq_valid[v]),
         .root      (root[v]),
         .side_out  (sq_side[v])
      );

      tfc_divide u_divide (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (sq_valid[v]),
         .len       (root[v]),
         .side      (sq_side[v]),
         .out_valid (dv_valid[v]),
         .res       (res[v])
      );
   end

   // Pack tangents; drop them all when any vertex or the determinant is degenerate.
   always_comb begin
      deg_in   = res[0].zero || res[1].zero || res[2].zero;
      data_in  = '0;
      lane_val = '0;
      for (int v = 0; v < 3; v++) begin
         for (int k = 0; k < 3; k++) begin
            lane_val = res[v].neg[k] ? -LANE_W'(res[v].quot[k]) : LANE_W'(res[v].quot[k]);
            data_in[v*VEC_W + k*LANE_W +: LANE_W] = deg_in ? '0 : lane_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= &dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= data_in;
         rsp_tuser_ff <= deg_in;
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_tdata_ff;
   assign rsp_tuser[0] = rsp_tuser_ff;

`ifndef SYNTH
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("degenerate result carries non-zero tangents");

   a_lanes_step: assert property (@(posedge clock) disable iff (reset)
      (dv_valid[0] == dv_valid[1]) && (dv_valid[1] == dv_valid[2]))
      else $error("vertex pipelines out of step");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      dv_valid[0] && !res[0].zero |->
         (res[0].quot[0] <= (Q_W'(1) << FRAC)) && (res[0].quot[1] <= (Q_W'(1) << FRAC))
         && (res[0].quot[2] <= (Q_W'(1) << FRAC)))
      else $error("tangent component above unit length");
`endif

endmodule

/* design/tfc_setup.sv */
// Edge vectors, texture deltas, determinant and unscaled tangent direction.
module tfc_setup (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  tfc_pkg::vec3_type pos,
   input  tfc_pkg::uv3_type  uv,
   input  tfc_pkg::vec3_type nrm,
   output logic              out_valid,
   output tfc_pkg::uvec_type u_vec,
   output logic              det_zero,
   output tfc_pkg::vec3_type nrm_out
);
   import tfc_pkg::*;

   logic                     v1_ff, v2_ff, v3_ff;
   logic [2:0][DIFF_W-1:0]   q1_in, q1_ff, q2_in, q2_ff;
   logic [DIFF_W-1:0]        du1_in, dv1_in, du2_in, dv2_in;
   logic [DIFF_W-1:0]        du1_ff, dv1_ff, du2_ff, dv2_ff;
   vec3_type                 n1_ff, n2_ff, n3_ff;
   logic [PROD_W-1:0]        pd1_in, pd2_in, pd1_ff, pd2_ff;
   logic [2:0][PROD_W-1:0]   pu1_in, pu2_in, pu1_ff, pu2_ff;
   logic [DET_W-1:0]         det;
   logic [DET_W-1:0]         ud;
   uvec_type                 u_in, u_ff;
   logic                     dz_in, dz_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         q1_in[k] = sdiff(pos[1][k*LANE_W +: LANE_W], pos[0][k*LANE_W +: LANE_W]);
         q2_in[k] = sdiff(pos[2][k*LANE_W +: LANE_W], pos[0][k*LANE_W +: LANE_W]);
      end
      du1_in = sdiff(uv[1][LANE_W-1:0], uv[0][LANE_W-1:0]);
      dv1_in = sdiff(uv[1][UV_W-1:LANE_W], uv[0][UV_W-1:LANE_W]);
      du2_in = sdiff(uv[2][LANE_W-1:0], uv[0][LANE_W-1:0]);
      dv2_in = sdiff(uv[2][UV_W-1:LANE_W], uv[0][UV_W-1:LANE_W]);
   end

   always_comb begin
      pd1_in = $signed(du1_ff) * $signed(dv2_ff);
      pd2_in = $signed(du2_ff) * $signed(dv1_ff);
      for (int k = 0; k < 3; k++) begin
         pu1_in[k] = $signed(dv2_ff) * $signed(q1_ff[k]);
         pu2_in[k] = $signed(dv1_ff) * $signed(q2_ff[k]);
      end
   end

   // Only the sign of the determinant matters once the result is normalised.
   always_comb begin
      det   = {pd1_ff[PROD_W-1], pd1_ff} - {pd2_ff[PROD_W-1], pd2_ff};
      dz_in = (det == '0);
      ud    = '0;
      for (int k = 0; k < 3; k++) begin
         ud       = {pu1_ff[k][PROD_W-1], pu1_ff[k]} - {pu2_ff[k][PROD_W-1], pu2_ff[k]};
         u_in[k]  = det[DET_W-1] ? -U_W'($signed(ud)) : U_W'($signed(ud));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q1_ff  <= q1_in;
         q2_ff  <= q2_in;
         du1_ff <= du1_in;
         dv1_ff <= dv1_in;
         du2_ff <= du2_in;
         dv2_ff <= dv2_in;
         n1_ff  <= nrm;
         pd1_ff <= pd1_in;
         pd2_ff <= pd2_in;
         pu1_ff <= pu1_in;
         pu2_ff <= pu2_in;
         n2_ff  <= n1_ff;
         u_ff   <= u_in;
         dz_ff  <= dz_in;
         n3_ff  <= n2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign u_vec     = u_ff;
   assign det_zero  = dz_ff;
   assign nrm_out   = n3_ff;

endmodule

/* design/tfc_project.sv */
// One vertex: remove the normal component, scale down and sum the squares.
module tfc_project (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  tfc_pkg::uvec_type               u_vec,
   input  logic [tfc_pkg::VEC_W-1:0]       nrm,
   input  logic                            det_zero,
   output logic                            out_valid,
   output logic [tfc_pkg::SQ_W-1:0]        sum_sq,
   output tfc_pkg::nrm_side_type           side
);
   import tfc_pkg::*;

   logic [6:0]              v_ff;
   logic [2:0][NP_W-1:0]    np_in, np_ff;
   uvec_type                u1_ff, u2_ff, u3_ff;
   logic [VEC_W-1:0]        n1_ff, n2_ff;
   logic                    dz1_ff, dz2_ff, dz3_ff, dz4_ff;
   logic [DOT_W-1:0]        dot;
   logic signed [63:0]      rnd_dot;
   logic [D_W-1:0]          d_in, d_ff;
   logic [2:0][DN_W-1:0]    dn_in, dn_ff;
   logic signed [63:0]      rnd_dn [3];
   logic [2:0][P_W-1:0]     p_in, p_ff;
   logic [2:0][P_W-1:0]     pmag;
   logic [P_W-1:0]          por;
   logic [SH_W-1:0]         sh;
   nrm_side_type            side_in, side_ff, side2_ff, side3_ff;
   logic [2:0][SQ_W-3:0]    sq_in, sq_ff;
   logic [SQ_W-1:0]         sum_in, sum_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         np_in[k] = $signed(u_vec[k]) * $signed(nrm[k*LANE_W +: LANE_W]);
      end
   end

   always_comb begin
      dot = DOT_W'($signed(np_ff[0])) + DOT_W'($signed(np_ff[1]))
          + DOT_W'($signed(np_ff[2]));
      rnd_dot = rnd_frac(64'($signed(dot)));
      d_in    = rnd_dot[D_W-1:0];
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dn_in[k] = $signed(d_ff) * $signed(n2_ff[k*LANE_W +: LANE_W]);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rnd_dn[k] = rnd_frac(64'($signed(dn_ff[k])));
         p_in[k]   = P_W'($signed(u3_ff[k])) - rnd_dn[k][P_W-1:0];
      end
   end

   // Shift so that the largest magnitude keeps at most A_W bits.
   always_comb begin
      por = '0;
      for (int k = 0; k < 3; k++) begin
         pmag[k] = p_ff[k][P_W-1] ? -p_ff[k] : p_ff[k];
         por     = por | pmag[k];
      end
      sh = '0;
      for (int j = A_W; j < P_W; j++) begin
         if (por[j]) sh = SH_W'(j - A_W + 1);
      end
      for (int k = 0; k < 3; k++) begin
         side_in.mag[k] = A_W'(pmag[k] >> sh);
         side_in.neg[k] = p_ff[k][P_W-1];
      end
      side_in.zero = (por == '0) || dz4_ff;
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = side_ff.mag[k] * side_ff.mag[k];
      end
      sum_in = SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         np_ff    <= np_in;
         u1_ff    <= u_vec;
         n1_ff    <= nrm;
         dz1_ff   <= det_zero;
         d_ff     <= d_in;
         u2_ff    <= u1_ff;
         n2_ff    <= n1_ff;
         dz2_ff   <= dz1_ff;
         dn_ff    <= dn_in;
         u3_ff    <= u2_ff;
         dz3_ff   <= dz2_ff;
         p_ff     <= p_in;
         dz4_ff   <= dz3_ff;
         side_ff  <= side_in;
         sq_ff    <= sq_in;
         side2_ff <= side_ff;
         sum_ff   <= sum_in;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = v_ff[6];
   assign sum_sq    = sum_ff;
   assign side      = side3_ff;

endmodule

/* design/tfc_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module tfc_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [tfc_pkg::SQ_W-1:0]    radicand,
   input  tfc_pkg::nrm_side_type       side_in,
   output logic                        out_valid,
   output logic [tfc_pkg::ROOT_W-1:0]  root,
   output tfc_pkg::nrm_side_type       side_out
);
   import tfc_pkg::*;

   logic [ISQ_STEPS:0]  v_s;
   logic [SQ_W-1:0]     n_s    [ISQ_STEPS+1];
   logic [SQ_W-1:0]     r_s    [ISQ_STEPS+1];
   nrm_side_type        side_s [ISQ_STEPS+1];

   assign v_s[0]    = in_valid;
   assign n_s[0]    = radicand;
   assign r_s[0]    = '0;
   assign side_s[0] = side_in;

   for (genvar i = 0; i < ISQ_STEPS; i++) begin : g_step
      localparam logic [SQ_W:0] BIT = (SQ_W + 1)'(1) << (SQ_W - 2 - 2 * i);
      logic [SQ_W:0]   rb;
      logic [SQ_W-1:0] n_in, r_in, n_ff, r_ff;
      logic            v_ff;
      nrm_side_type    side_ff;

      always_comb begin
         rb = {1'b0, r_s[i]} + BIT;
         if ({1'b0, n_s[i]} >= rb) begin
            n_in = n_s[i] - rb[SQ_W-1:0];
            r_in = (r_s[i] >> 1) + BIT[SQ_W-1:0];
         end else begin
            n_in = n_s[i];
            r_in = r_s[i] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv) begin
            v_ff <= v_s[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            n_ff    <= n_in;
            r_ff    <= r_in;
            side_ff <= side_s[i];
         end
      end

      assign v_s[i+1]    = v_ff;
      assign n_s[i+1]    = n_ff;
      assign r_s[i+1]    = r_ff;
      assign side_s[i+1] = side_ff;
   end

   assign out_valid = v_s[ISQ_STEPS];
   assign root      = r_s[ISQ_STEPS][ROOT_W-1:0];
   assign side_out  = side_s[ISQ_STEPS];

endmodule

/* design/tfc_divide.sv */
// Pipelined restoring divider: rounded mag * 2^14 / length for three lanes.
module tfc_divide (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [tfc_pkg::ROOT_W-1:0]  len,
   input  tfc_pkg::nrm_side_type       side,
   output logic                        out_valid,
   output tfc_pkg::tng_res_type        res
);
   import tfc_pkg::*;

   logic [2:0][NUM_W-1:0] num_in;
   logic [2:0][NUM_W-1:0] rem_s  [Q_W+1];
   logic [2:0][Q_W-1:0]   q_s    [Q_W+1];
   logic [ROOT_W-1:0]     len_s  [Q_W+1];
   logic [2:0]            neg_s  [Q_W+1];
   logic [Q_W:0]          zero_s;
   logic [Q_W+1:0]        v_s;
   logic [2:0][NUM_W-1:0] rem0_ff;
   logic [ROOT_W-1:0]     len0_ff;
   logic [2:0]            neg0_ff;
   logic                  zero0_ff, v0_ff;

   // Add half the divisor up front so the quotient comes out rounded.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num_in[k] = (NUM_W'(side.mag[k]) << FRAC) + NUM_W'(len >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= v_s[0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem0_ff  <= num_in;
         len0_ff  <= len;
         neg0_ff  <= side.neg;
         zero0_ff <= side.zero;
      end
   end

   assign v_s[0]    = in_valid;
   assign v_s[1]    = v0_ff;
   assign rem_s[0]  = rem0_ff;
   assign q_s[0]    = '0;
   assign len_s[0]  = len0_ff;
   assign neg_s[0]  = neg0_ff;
   assign zero_s[0] = zero0_ff;

   for (genvar i = 0; i < Q_W; i++) begin : g_step
      localparam int SHIFT = Q_W - 1 - i;
      logic [NUM_W:0]            dsor;
      logic [2:0][NUM_W-1:0]     rem_in, rem_ff;
      logic [2:0][Q_W-1:0]       q_in, q_ff;
      logic [ROOT_W-1:0]         len_ff;
      logic [2:0]                neg_ff;
      logic                      zero_ff, v_ff;

      always_comb begin
         dsor = (NUM_W + 1)'(len_s[i]) << SHIFT;
         for (int k = 0; k < 3; k++) begin
            if ({1'b0, rem_s[i][k]} >= dsor) begin
               rem_in[k] = rem_s[i][k] - dsor[NUM_W-1:0];
               q_in[k]   = q_s[i][k] | (Q_W'(1) << SHIFT);
            end else begin
               rem_in[k] = rem_s[i][k];
               q_in[k]   = q_s[i][k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (adv) begin
            v_ff <= v_s[i+1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff  <= rem_in;
            q_ff    <= q_in;
            len_ff  <= len_s[i];
            neg_ff  <= neg_s[i];
            zero_ff <= zero_s[i];
         end
      end

      assign v_s[i+2]    = v_ff;
      assign rem_s[i+1]  = rem_ff;
      assign q_s[i+1]    = q_ff;
      assign len_s[i+1]  = len_ff;
      assign neg_s[i+1]  = neg_ff;
      assign zero_s[i+1] = zero_ff;
   end

   assign out_valid = v_s[Q_W+1];
   assign res.quot  = q_s[Q_W];
   assign res.neg   = neg_s[Q_W];
   assign res.zero  = zero_s[Q_W] || (len_s[Q_W] == '0);

endmodule
